// File: src/sparse_command_list_expander_top_defines.svh
// Assertion macros for the sparse command list expander.
// Expects clk and rst_n in the scope of each use.
`ifndef SPARSE_COMMAND_LIST_EXPANDER_TOP_DEFINES_SVH
`define SPARSE_COMMAND_LIST_EXPANDER_TOP_DEFINES_SVH

// Property checked at every edge outside reset.
`define SCLX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent this cycle, consequent the next cycle.
`define SCLX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/sclx_pkg.sv
// Shared types and constants of the sparse command list expander.
// No dependencies.
package sclx_pkg;

  localparam int WORD_W      = 32;
  localparam int SLOT_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [WORD_W-1:0] CODE_MASK        = 32'h00FF_FFFF;
  localparam logic [WORD_W-1:0] START_TOKEN_RST  = 32'h0000_0001;
  localparam logic [WORD_W-1:0] SUBMIT_TOKEN_RST = 32'h0000_0002;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_STOP  = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_TOKEN  = 2'd0,
    CFG_SUBMIT_TOKEN = 2'd1
  } cfg_idx_t;

  // Work for the back end: lead word, zero words, submit, start, in that order.
  typedef struct packed {
    logic              lead_en;
    logic [WORD_W-1:0] lead_word;
    logic [SLOT_W-1:0] zeros;
    logic              submit_en;
    logic              start_en;
  } job_t;

endpackage

// File: src/sclx_if.sv
// Channel interfaces of the sparse command list expander.
// Depends on sclx_pkg.
interface sclx_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [sclx_pkg::WORD_W-1:0] data_word;
  modport source (output valid, output opcode, output data_word, input ready);
  modport sink (input valid, input opcode, input data_word, output ready);
endinterface

interface sclx_out_if;
  logic                      valid;
  logic                      ready;
  logic [sclx_pkg::WORD_W-1:0] out_word;
  logic                      last;
  modport source (output valid, output out_word, output last, input ready);
  modport sink (input valid, input out_word, input last, output ready);
endinterface

interface sclx_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sclx_pkg::CFG_IDX_W-1:0] index;
  logic [sclx_pkg::WORD_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/sclx_front.sv
// Front end: accepts input words, tracks transfer and slot state, emits jobs.
// Depends on sclx_pkg and sclx_in_if.
module sclx_front #(
  parameter int PARAMS_PER_COMMAND = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  sclx_in_if.sink       in_ch,
  output sclx_pkg::job_t job_o,
  output logic          push_o,
  input  logic          full_i
);

  logic                              open_r, open_nxt;
  logic                              hdr_r, hdr_nxt;
  logic [sclx_pkg::SLOT_W-1:0]       slot_r, slot_nxt;
  logic [PARAMS_PER_COMMAND-1:0]     mask_r, mask_nxt;

  logic                              acc;
  logic                              has_words;
  logic [PARAMS_PER_COMMAND-1:0]     mask_use;
  logic [sclx_pkg::SLOT_W-1:0]       spos;
  logic [sclx_pkg::SLOT_W-1:0]       cnt;
  logic [sclx_pkg::SLOT_W-1:0]       end_pos;
  logic                              found;

  assign in_ch.ready = !full_i;
  assign acc         = in_ch.valid && in_ch.ready;
  assign push_o      = acc && has_words;

  always_comb begin
    job_o     = '0;
    has_words = 1'b0;
    open_nxt  = open_r;
    hdr_nxt   = hdr_r;
    slot_nxt  = slot_r;
    mask_nxt  = mask_r;

    mask_use = hdr_r ? in_ch.data_word[24 +: PARAMS_PER_COMMAND] : mask_r;
    spos     = hdr_r ? '0 : slot_r + sclx_pkg::SLOT_W'(1);

    // absent slots after the current one, up to the next present parameter
    cnt   = '0;
    found = 1'b0;
    for (int i = 0; i < PARAMS_PER_COMMAND; i++) begin
      if (sclx_pkg::SLOT_W'(i) >= spos && !found) begin
        if (mask_use[i]) begin
          found = 1'b1;
        end else begin
          cnt = cnt + sclx_pkg::SLOT_W'(1);
        end
      end
    end
    end_pos = spos + cnt;

    case (sclx_pkg::opcode_t'(in_ch.opcode))
      sclx_pkg::OP_START: begin
        if (open_r) begin
          job_o.zeros = hdr_r ? sclx_pkg::SLOT_W'(PARAMS_PER_COMMAND + 1)
                              : sclx_pkg::SLOT_W'(PARAMS_PER_COMMAND) - slot_r;
        end
        job_o.submit_en = open_r;
        job_o.start_en  = 1'b1;
        has_words       = 1'b1;
        open_nxt        = 1'b1;
        hdr_nxt         = 1'b1;
      end
      sclx_pkg::OP_DATA: begin
        if (open_r) begin
          job_o.lead_en   = 1'b1;
          job_o.lead_word = hdr_r ? (in_ch.data_word & sclx_pkg::CODE_MASK)
                                  : in_ch.data_word;
          job_o.zeros     = cnt;
          has_words       = 1'b1;
          mask_nxt        = mask_use;
          if (end_pos >= sclx_pkg::SLOT_W'(PARAMS_PER_COMMAND)) begin
            hdr_nxt = 1'b1;
          end else begin
            hdr_nxt  = 1'b0;
            slot_nxt = end_pos;
          end
        end
      end
      sclx_pkg::OP_STOP: begin
        if (open_r) begin
          job_o.submit_en = 1'b1;
          has_words       = 1'b1;
          open_nxt        = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      hdr_r  <= 1'b1;
      slot_r <= '0;
      mask_r <= '0;
    end else if (acc) begin
      open_r <= open_nxt;
      hdr_r  <= hdr_nxt;
      slot_r <= slot_nxt;
      mask_r <= mask_nxt;
    end
  end

endmodule

// File: src/sclx_queue.sv
// Two-entry job queue between front and back ends.
// Depends on sclx_pkg.
module sclx_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  sclx_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output sclx_pkg::job_t head_o
);

  localparam int PTR_W = $clog2(sclx_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(sclx_pkg::QUEUE_DEPTH + 1);

  sclx_pkg::job_t    entries_r [sclx_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full_o       = (cnt_r == CNT_W'(sclx_pkg::QUEUE_DEPTH));
  assign head_valid_o = (cnt_r != '0);
  assign head_o       = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_i ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_i ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      entries_r[wr_ptr_r] <= push_job_i;
    end
  end

endmodule

// File: src/sclx_back.sv
// Back end: token registers and word sequencer feeding the output register.
// Depends on sclx_pkg, sclx_out_if, sclx_cfg_if and the defines header.
`include "sparse_command_list_expander_top_defines.svh"

module sclx_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid_i,
  input  sclx_pkg::job_t head_i,
  output logic           pop_o,
  sclx_cfg_if.sink       cfg_ch,
  sclx_out_if.source     out_ch
);

  logic [sclx_pkg::WORD_W-1:0] start_tok_r;
  logic [sclx_pkg::WORD_W-1:0] submit_tok_r;

  logic                        busy_r, busy_nxt;
  sclx_pkg::job_t              job_r, job_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [sclx_pkg::WORD_W-1:0] out_word_r, out_word_nxt;
  logic                        out_last_r, out_last_nxt;

  sclx_pkg::job_t              cur;
  logic                        have;
  logic                        adv;
  logic                        done;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_tok_r  <= sclx_pkg::START_TOKEN_RST;
      submit_tok_r <= sclx_pkg::SUBMIT_TOKEN_RST;
    end else if (cfg_ch.valid) begin
      case (sclx_pkg::cfg_idx_t'(cfg_ch.index))
        sclx_pkg::CFG_START_TOKEN:  start_tok_r  <= cfg_ch.data;
        sclx_pkg::CFG_SUBMIT_TOKEN: submit_tok_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // first word of a job goes out straight from the queue head
  assign cur   = busy_r ? job_r : head_i;
  assign have  = busy_r || head_valid_i;
  assign adv   = have && (!out_valid_r || out_ch.ready);
  assign pop_o = adv && !busy_r;

  always_comb begin
    job_nxt      = cur;
    out_word_nxt = out_word_r;
    if (cur.lead_en) begin
      out_word_nxt    = cur.lead_word;
      job_nxt.lead_en = 1'b0;
    end else if (cur.zeros != '0) begin
      out_word_nxt  = '0;
      job_nxt.zeros = cur.zeros - sclx_pkg::SLOT_W'(1);
    end else if (cur.submit_en) begin
      out_word_nxt      = submit_tok_r;
      job_nxt.submit_en = 1'b0;
    end else begin
      out_word_nxt     = start_tok_r;
      job_nxt.start_en = 1'b0;
    end
    done = !job_nxt.lead_en && (job_nxt.zeros == '0) &&
           !job_nxt.submit_en && !job_nxt.start_en;

    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      busy_nxt      = !done;
      out_valid_nxt = 1'b1;
      out_last_nxt  = done;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job_r      <= job_nxt;
      out_word_r <= out_word_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_word = out_word_r;
  assign out_ch.last     = out_last_r;

  `SCLX_ASSERT(a_busy_has_work, busy_r |-> (job_r.lead_en || job_r.zeros != '0 || job_r.submit_en || job_r.start_en), "busy with empty job")
  `SCLX_ASSERT(a_pop_needs_head, pop_o |-> head_valid_i, "pop from empty queue")
  `SCLX_ASSERT_NEXT(a_last_ends_job, adv && done, !busy_r && out_ch.last, "last word left job open")
  `SCLX_ASSERT_NEXT(a_more_keeps_busy, adv && !done, busy_r && !out_ch.last, "job dropped before last word")

endmodule

// File: src/sparse_command_list_expander_top.sv
// The first word of an item passes through the job queue, then the output register.
// Throughput: one output word per cycle unless out_ch.ready holds it back or no job is waiting;
// an item yields 1 to 11 words (a zero-parameter command 9) through the single output register.
// Items that yield nothing push no job. A 2-entry job queue decouples input.
// Reset (synchronous, rst_n low): no transfer open, header expected, queue empty,
// start token 1, submit token 2.
module sparse_command_list_expander_top #(
  parameter int PARAMS_PER_COMMAND = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  sclx_in_if.sink    in_ch,
  sclx_out_if.source out_ch,
  sclx_cfg_if.sink   cfg_ch
);

  sclx_pkg::job_t push_job;
  sclx_pkg::job_t head_job;
  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;

  sclx_front #(
    .PARAMS_PER_COMMAND(PARAMS_PER_COMMAND)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .job_o  (push_job),
    .push_o (push),
    .full_i (full)
  );

  sclx_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_job)
  );

  sclx_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .cfg_ch       (cfg_ch),
    .out_ch       (out_ch)
  );

endmodule
